### rtl/cppt_pkg.sv
// shared types and constants for the convex polygon point test
`default_nettype none

package cppt_pkg;

    // coordinate width of one signed Q24.8 value
    localparam int COORD_W = 32;
    // width of one stored vertex: x in the upper half, y in the lower half
    localparam int VERT_W = 2 * COORD_W;
    // width of the reported vertex total
    localparam int TOTAL_W = 6;
    // default vertex capacity
    localparam int MAX_VERTICES_DEF = 32;

    // item kinds
    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    // sign of one edge cross product
    typedef enum logic [1:0] {
        SIGN_ZERO,
        SIGN_POS,
        SIGN_NEG
    } sign_t;

    // control that travels with one edge through the cross product pipe
    typedef struct packed {
        logic valid;
        logic last;
    } edge_tag_t;

endpackage

`default_nettype wire

### rtl/cppt_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module cppt_ram #(
    parameter int WIDTH = cppt_pkg::VERT_W,
    parameter int DEPTH = cppt_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/cppt_cross.sv
// three stage pipe that gives the sign of (p - v0) x (v1 - v0) for one edge
`default_nettype none

module cppt_cross (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire cppt_pkg::edge_tag_t                   edge_tag,
    input  wire logic signed [cppt_pkg::COORD_W-1:0]   px,
    input  wire logic signed [cppt_pkg::COORD_W-1:0]   py,
    input  wire logic signed [cppt_pkg::COORD_W-1:0]   x0,
    input  wire logic signed [cppt_pkg::COORD_W-1:0]   y0,
    input  wire logic signed [cppt_pkg::COORD_W-1:0]   x1,
    input  wire logic signed [cppt_pkg::COORD_W-1:0]   y1,
    output cppt_pkg::edge_tag_t                        sign_tag,
    output cppt_pkg::sign_t                            sign
);

    localparam int DIF_W  = cppt_pkg::COORD_W + 1;
    localparam int PROD_W = 2 * DIF_W;
    localparam int CMP_W  = PROD_W + 1;

    cppt_pkg::edge_tag_t      tag1_reg, tag2_reg, tag3_reg;
    logic signed [DIF_W-1:0]  ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [PROD_W-1:0] m1_reg, m2_reg;
    logic signed [CMP_W-1:0]  diff;
    cppt_pkg::sign_t          sign_reg, sign_next;

    // tag pipe follows the data stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= edge_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // stage 1: edge and point differences
    always_ff @(posedge clk)
    begin
        ax_reg <= DIF_W'(px) - DIF_W'(x0);
        ay_reg <= DIF_W'(py) - DIF_W'(y0);
        bx_reg <= DIF_W'(x1) - DIF_W'(x0);
        by_reg <= DIF_W'(y1) - DIF_W'(y0);
    end

    // stage 2: the two partial cross products
    always_ff @(posedge clk)
    begin
        m1_reg <= ax_reg * by_reg;
        m2_reg <= ay_reg * bx_reg;
    end

    // stage 3: compare the products
    always_comb
    begin
        diff = CMP_W'(m1_reg) - CMP_W'(m2_reg);
        if (diff == '0)
        begin
            sign_next = cppt_pkg::SIGN_ZERO;
        end
        else if (diff[CMP_W-1])
        begin
            sign_next = cppt_pkg::SIGN_NEG;
        end
        else
        begin
            sign_next = cppt_pkg::SIGN_POS;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
    end

    assign sign_tag = tag3_reg;
    assign sign     = sign_reg;

endmodule

`default_nettype wire

### rtl/convex_polygon_point_test.sv
// Point in convex polygon test over a stored vertex list in signed Q24.8.
// An append or a clear leaves busy low. A query on a list of n vertices with
// n >= 2 keeps busy high while the vertex ram is read once per
// cycle, n + 1 reads including the wrap back to the first vertex, and while
// the edges pass the cross product and compare pipe; the done strobe comes in
// the cycle busy drops, and the next item may be accepted in that cycle.
// A query on fewer than two vertices answers inside in the cycle after it is
// accepted. The result is shown on inside_res, vertex_total and overflowed
// for the single cycle that done is high; the receiver cannot hold it off.
`default_nettype none

module convex_polygon_point_test #(
    parameter int MAX_VERTICES = cppt_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          kind,
    input  wire logic signed [cppt_pkg::COORD_W-1:0] x_coord,
    input  wire logic signed [cppt_pkg::COORD_W-1:0] y_coord,
    output logic                                     done,
    output logic                                     inside_res,
    output logic [cppt_pkg::TOTAL_W-1:0]             vertex_total,
    output logic                                     overflowed
);

    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    cppt_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             have_sign_reg, have_sign_next;
    cppt_pkg::sign_t  prev_sign_reg, prev_sign_next;
    logic             fail_reg, fail_next;
    logic             done_reg, done_next;
    logic             inside_reg, inside_next;
    logic [cppt_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic             ovfo_reg, ovfo_next;

    logic signed [cppt_pkg::COORD_W-1:0] px_reg, py_reg;
    logic signed [cppt_pkg::COORD_W-1:0] pvx_reg, pvy_reg;
    logic             rvalid_reg, rfirst_reg, rlast_reg;

    logic                        accept;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [cppt_pkg::VERT_W-1:0] wr_data;
    logic                        rd_en;
    logic                        wrap;
    logic [ADDR_W-1:0]           rd_addr;
    logic [cppt_pkg::VERT_W-1:0] rd_data;
    logic signed [cppt_pkg::COORD_W-1:0] cvx, cvy;

    cppt_pkg::edge_tag_t edge_tag;
    cppt_pkg::edge_tag_t sign_tag;
    cppt_pkg::sign_t     sign;
    logic                pair_bad;

    assign busy   = (state_reg != cppt_pkg::ST_IDLE);
    assign accept = start && !busy;

    // vertex append goes straight into the ram on the accepted beat while the list is not full
    assign wr_en   = accept && (kind == cppt_pkg::KIND_APPEND) && (count_reg < MAX_CNT);
    assign wr_addr = count_reg[ADDR_W-1:0];
    assign wr_data = {x_coord, y_coord};

    // walk reads vertex 0 .. n-1, then vertex 0 again for the closing edge
    assign rd_en   = (state_reg == cppt_pkg::ST_WALK);
    assign wrap    = (iss_reg == count_reg);
    assign rd_addr = wrap ? '0 : iss_reg[ADDR_W-1:0];

    cppt_ram #(
        .WIDTH (cppt_pkg::VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_vert_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign cvx = rd_data[cppt_pkg::VERT_W-1:cppt_pkg::COORD_W];
    assign cvy = rd_data[cppt_pkg::COORD_W-1:0];

    // read tags, aligned with the ram data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
            rfirst_reg <= 1'b0;
            rlast_reg  <= 1'b0;
        end
        else
        begin
            rvalid_reg <= rd_en;
            rfirst_reg <= (iss_reg == '0);
            rlast_reg  <= wrap;
        end
    end

    // previous vertex and query point
    always_ff @(posedge clk)
    begin
        if (rvalid_reg)
        begin
            pvx_reg <= cvx;
            pvy_reg <= cvy;
        end
        if (accept)
        begin
            px_reg <= x_coord;
            py_reg <= y_coord;
        end
    end

    // one edge per ram read after the first
    assign edge_tag.valid = rvalid_reg && !rfirst_reg;
    assign edge_tag.last  = rlast_reg;

    cppt_cross u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .edge_tag (edge_tag),
        .px       (px_reg),
        .py       (py_reg),
        .x0       (pvx_reg),
        .y0       (pvy_reg),
        .x1       (cvx),
        .y1       (cvy),
        .sign_tag (sign_tag),
        .sign     (sign)
    );

    // consecutive signs must agree and be nonzero
    assign pair_bad = have_sign_reg &&
                      ((sign == cppt_pkg::SIGN_ZERO) ||
                       (prev_sign_reg == cppt_pkg::SIGN_ZERO) ||
                       (sign != prev_sign_reg));

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cppt_pkg::ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            iss_reg       <= '0;
            have_sign_reg <= 1'b0;
            prev_sign_reg <= cppt_pkg::SIGN_ZERO;
            fail_reg      <= 1'b0;
            done_reg      <= 1'b0;
            inside_reg    <= 1'b0;
            total_reg     <= '0;
            ovfo_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            iss_reg       <= iss_next;
            have_sign_reg <= have_sign_next;
            prev_sign_reg <= prev_sign_next;
            fail_reg      <= fail_next;
            done_reg      <= done_next;
            inside_reg    <= inside_next;
            total_reg     <= total_next;
            ovfo_reg      <= ovfo_next;
        end
    end

    // next state and result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        iss_next       = iss_reg;
        have_sign_next = have_sign_reg;
        prev_sign_next = prev_sign_reg;
        fail_next      = fail_reg;
        done_next      = 1'b0;
        inside_next    = inside_reg;
        total_next     = total_reg;
        ovfo_next      = ovfo_reg;

        case (state_reg)
            cppt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        cppt_pkg::KIND_APPEND:
                        begin
                            if (count_reg < MAX_CNT)
                            begin
                                count_next = count_reg + ONE_CNT;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        cppt_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        cppt_pkg::KIND_QUERY:
                        begin
                            total_next = cppt_pkg::TOTAL_W'(count_reg);
                            ovfo_next  = ovf_reg;
                            if (count_reg <= ONE_CNT)
                            begin
                                done_next   = 1'b1;
                                inside_next = 1'b1;
                            end
                            else
                            begin
                                state_next     = cppt_pkg::ST_WALK;
                                iss_next       = '0;
                                have_sign_next = 1'b0;
                                fail_next      = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            cppt_pkg::ST_WALK:
            begin
                iss_next = iss_reg + ONE_CNT;
                if (wrap)
                begin
                    state_next = cppt_pkg::ST_DRAIN;
                end
            end
            cppt_pkg::ST_DRAIN:
            begin
            end
            default:
            begin
                state_next = cppt_pkg::ST_IDLE;
            end
        endcase

        // edge signs coming out of the pipe
        if (sign_tag.valid)
        begin
            have_sign_next = 1'b1;
            prev_sign_next = sign;
            if (pair_bad)
            begin
                fail_next = 1'b1;
            end
            if (sign_tag.last)
            begin
                done_next   = 1'b1;
                inside_next = !(fail_reg || pair_bad);
                state_next  = cppt_pkg::ST_IDLE;
            end
        end
    end

    assign done         = done_reg;
    assign inside_res   = inside_reg;
    assign vertex_total = total_reg;
    assign overflowed   = ovfo_reg;

    // the result strobe only comes once the walk is over
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // the ram is never written during a walk
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == cppt_pkg::ST_IDLE))
        else $error("vertex write during query");

    // the count never passes the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("vertex count beyond capacity");

    // a query on fewer than two vertices answers inside without a walk
    a_short_query: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == cppt_pkg::KIND_QUERY) && (count_reg <= ONE_CNT))
        |=> (done && inside_res))
        else $error("short query not answered inside");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the convex polygon point test: directed table, then random polygons
module testbench;

    localparam int MAX_VERT = cppt_pkg::MAX_VERTICES_DEF;
    localparam int ITEM_GOAL = 550;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 50;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic signed [cppt_pkg::COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [cppt_pkg::COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

    // one query answer
    typedef struct packed {
        logic                         in_poly;
        logic [cppt_pkg::TOTAL_W-1:0] total;
        logic                         ovf;
    } answer_t;

    // one row of the directed table
    typedef struct packed {
        logic [1:0]                          k;
        logic signed [cppt_pkg::COORD_W-1:0] xv;
        logic signed [cppt_pkg::COORD_W-1:0] yv;
        int                                  reps;
        bit                                  typed;
        answer_t                             want;
    } stim_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic [1:0]                          kind;
    logic signed [cppt_pkg::COORD_W-1:0] x_coord;
    logic signed [cppt_pkg::COORD_W-1:0] y_coord;
    logic                                done;
    logic                                inside_res;
    logic [cppt_pkg::TOTAL_W-1:0]        vertex_total;
    logic                                overflowed;

    // mirror of the vertex list and overflow flag
    logic signed [cppt_pkg::COORD_W-1:0] poly_x [MAX_VERT];
    logic signed [cppt_pkg::COORD_W-1:0] poly_y [MAX_VERT];
    int                        poly_count = 0;
    bit                        poly_overflow = 1'b0;

    answer_t   pending_answers [$];
    stim_row_t directed_rows [$];
    int        fail_count = 0;
    int        items_sent = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;

    convex_polygon_point_test #(
        .MAX_VERTICES (MAX_VERT)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .done         (done),
        .inside_res   (inside_res),
        .vertex_total (vertex_total),
        .overflowed   (overflowed)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // exact sign of (P - V[i]) x (V[j] - V[i])
    function automatic cppt_pkg::sign_t edge_sign(
        input logic signed [cppt_pkg::COORD_W-1:0] px,
        input logic signed [cppt_pkg::COORD_W-1:0] py,
        input int i, input int j);
        logic signed [cppt_pkg::COORD_W+1:0] ax, ay, bx, by;
        logic signed [2*cppt_pkg::COORD_W+3:0] lhs, rhs;
        ax = px - poly_x[i];
        ay = py - poly_y[i];
        bx = poly_x[j] - poly_x[i];
        by = poly_y[j] - poly_y[i];
        lhs = ax * by;
        rhs = ay * bx;
        if (lhs == rhs)
            return cppt_pkg::SIGN_ZERO;
        else if (lhs > rhs)
            return cppt_pkg::SIGN_POS;
        return cppt_pkg::SIGN_NEG;
    endfunction

    // walk the edges with wrap; any zero or sign change means outside
    function automatic logic point_inside(input logic signed [cppt_pkg::COORD_W-1:0] px,
                                          input logic signed [cppt_pkg::COORD_W-1:0] py);
        cppt_pkg::sign_t prev;
        cppt_pkg::sign_t cur;
        int    j;
        prev = cppt_pkg::SIGN_ZERO;
        for (int i = 0; i < poly_count; i++)
        begin
            j = (i + 1 == poly_count) ? 0 : i + 1;
            cur = edge_sign(px, py, i, j);
            if (i > 0 && (cur == cppt_pkg::SIGN_ZERO || prev == cppt_pkg::SIGN_ZERO ||
                          cur != prev))
                return 1'b0;
            prev = cur;
        end
        return 1'b1;
    endfunction

    // update the mirror for one accepted beat and queue the answer of a query
    function automatic void apply_beat(input logic [1:0] k,
                                       input logic signed [cppt_pkg::COORD_W-1:0] xv,
                                       input logic signed [cppt_pkg::COORD_W-1:0] yv,
                                       input bit typed, input answer_t want);
        answer_t ans;
        case (k)
            cppt_pkg::KIND_APPEND:
            begin
                if (poly_count < MAX_VERT)
                begin
                    poly_x[poly_count] = xv;
                    poly_y[poly_count] = yv;
                    poly_count++;
                end
                else
                    poly_overflow = 1'b1;
            end
            cppt_pkg::KIND_CLEAR:
            begin
                poly_count = 0;
                poly_overflow = 1'b0;
            end
            cppt_pkg::KIND_QUERY:
            begin
                ans.in_poly = point_inside(xv, yv);
                ans.total = poly_count[cppt_pkg::TOTAL_W-1:0];
                ans.ovf = poly_overflow;
                pending_answers.insert(pending_answers.size(), typed ? want : ans);
            end
            default:
            begin
            end
        endcase
    endfunction

    // drive one beat at the falling edge, hold it until busy is low at a rising edge
    task automatic send_item(input logic [1:0] k,
                             input logic signed [cppt_pkg::COORD_W-1:0] xv,
                             input logic signed [cppt_pkg::COORD_W-1:0] yv,
                             input bit typed = 1'b0, input answer_t want = '0);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        start <= 1'b1;
        kind <= k;
        x_coord <= xv;
        y_coord <= yv;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        apply_beat(k, xv, yv, typed, want);
        if (k != KIND_UNUSED)
            items_sent++;
    endtask

    function automatic void add_row(input logic [1:0] k,
                                    input logic signed [cppt_pkg::COORD_W-1:0] xv,
                                    input logic signed [cppt_pkg::COORD_W-1:0] yv,
                                    input int reps = 1, input bit typed = 1'b0,
                                    input logic w_in = 1'b0,
                                    input logic [cppt_pkg::TOTAL_W-1:0] w_tot = '0,
                                    input logic w_ovf = 1'b0);
        stim_row_t r;
        r.k = k;
        r.xv = xv;
        r.yv = yv;
        r.reps = reps;
        r.typed = typed;
        r.want.in_poly = w_in;
        r.want.total = w_tot;
        r.want.ovf = w_ovf;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // one random round: a convex polygon or a short list with queries around it, or noise
    task automatic random_round();
        int shape, n, stored, pick, k, j, x0, y0, dx, a, sp;
        int vx [64];
        int vy [64];
        logic signed [cppt_pkg::COORD_W-1:0] px, py;
        shape = $urandom_range(0, 9);
        // noise: any kind, any coordinates, no clear first
        if (shape == 9)
        begin
            repeat ($urandom_range(1, 6))
                send_item(2'($urandom_range(0, 3)), $urandom, $urandom);
            return;
        end
        if (shape == 8)
        begin
            // short lists over the full coordinate range, empty to four vertices
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
            begin
                vx[i] = $urandom;
                vy[i] = $urandom;
            end
        end
        else
        begin
            // points on a parabola are always in convex position
            n = (shape <= 5) ? $urandom_range(3, 8) :
                (shape == 6) ? $urandom_range(9, 32) : $urandom_range(33, 40);
            x0 = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
            y0 = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
            dx = 2 * int'($urandom_range(1, 32'h2_0000));
            a = 2 * int'($urandom_range(1, 512));
            if ($urandom_range(0, 1) == 1)
                dx = -dx;
            if ($urandom_range(0, 1) == 1)
                a = -a;
            for (int i = 0; i < n; i++)
            begin
                vx[i] = x0 + i * dx;
                vy[i] = y0 + a * i * i;
            end
        end
        send_item(cppt_pkg::KIND_CLEAR, $urandom, $urandom);
        for (int i = 0; i < n; i++)
            send_item(cppt_pkg::KIND_APPEND, vx[i], vy[i]);
        stored = (n < MAX_VERT) ? n : MAX_VERT;
        repeat ($urandom_range(1, 6))
        begin
            if (shape == 8)
                pick = (stored > 0 && $urandom_range(0, 1) == 1) ? 0 : 4;
            else
                pick = $urandom_range(0, 4);
            k = (stored > 0) ? $urandom_range(0, stored - 1) : 0;
            j = (k + 1 == stored) ? 0 : k + 1;
            sp = int'($urandom_range(0, 8192)) - 4096;
            case (pick)
                // on a vertex
                0:
                begin
                    px = vx[k];
                    py = vy[k];
                end
                // on an edge, exact since all coordinate sums are even
                1:
                begin
                    px = (vx[k] + vx[j]) / 2;
                    py = (vy[k] + vy[j]) / 2;
                end
                // interior point from three vertices
                2:
                begin
                    px = (vx[0] + vx[1] + vx[2]) / 3;
                    py = (vy[0] + vy[1] + vy[2]) / 3;
                end
                // near a vertex
                3:
                begin
                    px = vx[k] + sp;
                    py = vy[k] - sp / 2;
                end
                default:
                begin
                    px = $urandom;
                    py = $urandom;
                end
            endcase
            send_item(cppt_pkg::KIND_QUERY, px, py);
        end
    endtask

    // check each result beat against the oldest pending answer
    always @(posedge clk)
    begin : result_check
        answer_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result beat with no query pending");
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (inside_res !== want.in_poly)
                begin
                    $error("inside_res: expected %0d, actual %0d", want.in_poly, inside_res);
                    fail_count++;
                end
                if (vertex_total !== want.total)
                begin
                    $error("vertex_total: expected %0d, actual %0d", want.total, vertex_total);
                    fail_count++;
                end
                if (overflowed !== want.ovf)
                begin
                    $error("overflowed: expected %0d, actual %0d", want.ovf, overflowed);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        kind = cppt_pkg::KIND_APPEND;
        x_coord = '0;
        y_coord = '0;

        // directed table: empty, single, two vertices, square, extremes, full list
        add_row(cppt_pkg::KIND_QUERY, 0, 0, 1, 1'b1, 1'b1, 6'd0, 1'b0);
        add_row(cppt_pkg::KIND_QUERY, C_MIN, C_MAX, 1, 1'b1, 1'b1, 6'd0, 1'b0);
        add_row(cppt_pkg::KIND_APPEND, 0, 0);
        add_row(cppt_pkg::KIND_QUERY, C_MAX, C_MIN, 1, 1'b1, 1'b1, 6'd1, 1'b0);
        add_row(cppt_pkg::KIND_APPEND, 4096, 0);
        add_row(cppt_pkg::KIND_QUERY, 2048, 256);
        add_row(cppt_pkg::KIND_APPEND, 4096, 4096);
        add_row(cppt_pkg::KIND_APPEND, 0, 4096);
        add_row(cppt_pkg::KIND_QUERY, 2048, 2048);
        add_row(cppt_pkg::KIND_QUERY, 2048, 0);
        add_row(cppt_pkg::KIND_QUERY, 0, 0);
        add_row(cppt_pkg::KIND_QUERY, 8192, 2048);
        add_row(KIND_UNUSED, C_MIN, C_MAX);
        add_row(cppt_pkg::KIND_QUERY, 2048, 2048);
        add_row(cppt_pkg::KIND_CLEAR, C_MAX, C_MIN);
        add_row(cppt_pkg::KIND_QUERY, 0, 0, 1, 1'b1, 1'b1, 6'd0, 1'b0);
        add_row(cppt_pkg::KIND_APPEND, C_MIN, C_MIN);
        add_row(cppt_pkg::KIND_APPEND, C_MAX, C_MIN);
        add_row(cppt_pkg::KIND_APPEND, C_MAX, C_MAX);
        add_row(cppt_pkg::KIND_APPEND, C_MIN, C_MAX);
        add_row(cppt_pkg::KIND_QUERY, 0, 0);
        add_row(cppt_pkg::KIND_QUERY, C_MAX, C_MAX);
        add_row(cppt_pkg::KIND_CLEAR, 0, 0);
        // one more append than fits, all on one point
        add_row(cppt_pkg::KIND_APPEND, 7, -9, MAX_VERT + 1);
        add_row(cppt_pkg::KIND_QUERY, 7, -9, 1, 1'b1, 1'b0, 6'd32, 1'b1);
        add_row(cppt_pkg::KIND_CLEAR, 0, 0);
        add_row(cppt_pkg::KIND_QUERY, -1, -1, 1, 1'b1, 1'b1, 6'd0, 1'b0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            repeat (directed_rows[r].reps)
                send_item(directed_rows[r].k, directed_rows[r].xv, directed_rows[r].yv,
                          directed_rows[r].typed, directed_rows[r].want);

        while (items_sent < ITEM_GOAL)
            random_round();

        @(negedge clk);
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
